// ----- src/jsu_pkg.sv -----
// Shared types, codes and character helpers for the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_CHAR     = 3'd0,
    ST_CLOSED   = 3'd1,
    ST_BADESC   = 3'd2,
    ST_BADHEX   = 3'd3,
    ST_UNCLOSED = 3'd4
  } status_e;

  localparam logic [15:0] CharU         = 16'h0075;
  localparam logic [15:0] CharBackslash = 16'h005C;
  localparam logic [15:0] CharQuote     = 16'h0022;
  localparam logic [15:0] CharSlash     = 16'h002F;
  localparam logic [15:0] CharB         = 16'h0062;
  localparam logic [15:0] CharF         = 16'h0066;
  localparam logic [15:0] CharN         = 16'h006E;
  localparam logic [15:0] CharR         = 16'h0072;
  localparam logic [15:0] CharT         = 16'h0074;
  localparam logic [1:0]  HexLastDigit  = 2'd3;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        text_ended;
  } in_item_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [15:0] decoded_char;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_value(logic [15:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      h.value = 4'(c - 16'h0030);
    end else if (c >= 16'h0061 && c <= 16'h0066) begin
      h.value = 4'(c - 16'h0057);
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      h.value = 4'(c - 16'h0037);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [15:0] escape_char(logic [15:0] c);
    logic [15:0] r;
    case (c)
      CharB:         r = 16'h0008;
      CharR:         r = 16'h000D;
      CharN:         r = 16'h000A;
      CharSlash:     r = CharSlash;
      CharQuote:     r = CharQuote;
      CharF:         r = 16'h000C;
      CharBackslash: r = CharBackslash;
      CharT:         r = 16'h0009;
      default:       r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

// ----- src/jsu_if.sv -----
// Valid/ready channel interfaces for input code units and decoded results.
interface jsu_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        text_ended;

  modport source (output valid, output code_unit, output text_ended, input ready);
  modport sink   (input valid, input code_unit, input text_ended, output ready);
endinterface

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] decoded_char;

  modport source (output valid, output status, output decoded_char, input ready);
  modport sink   (input valid, input status, input decoded_char, output ready);
endinterface

// ----- src/jsu_decode.sv -----
// Escape decoder: scan state registers and the per-item decode logic.
module jsu_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  jsu_pkg::in_item_t item_i,
  output jsu_pkg::result_t  result_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [11:0]    acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_NORMAL;
      cnt_q  <= 2'd0;
      acc_q  <= 12'd0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
    end
  end

  always_comb begin
    logic [15:0]    c;
    logic [15:0]    esc;
    jsu_pkg::hex_t  hex;
    c   = item_i.code_unit;
    esc = jsu_pkg::escape_char(c);
    hex = jsu_pkg::hex_value(c);
    mode_d   = jsu_pkg::MODE_NORMAL;
    cnt_d    = 2'd0;
    acc_d    = 12'd0;
    result_o = '{valid: 1'b0, status: jsu_pkg::ST_CHAR, decoded_char: 16'd0};
    if (item_i.text_ended) begin
      result_o.valid  = 1'b1;
      result_o.status = jsu_pkg::ST_UNCLOSED;
    end else begin
      case (mode_q)
        jsu_pkg::MODE_ESCAPE: begin
          if (c == jsu_pkg::CharU) begin
            mode_d = jsu_pkg::MODE_HEX;
          end else if (esc == 16'd0) begin
            result_o.valid  = 1'b1;
            result_o.status = jsu_pkg::ST_BADESC;
          end else begin
            result_o.valid        = 1'b1;
            result_o.decoded_char = esc;
          end
        end
        jsu_pkg::MODE_HEX: begin
          if (!hex.ok) begin
            result_o.valid  = 1'b1;
            result_o.status = jsu_pkg::ST_BADHEX;
          end else if (cnt_q != jsu_pkg::HexLastDigit) begin
            mode_d = jsu_pkg::MODE_HEX;
            cnt_d  = cnt_q + 2'd1;
            acc_d  = {acc_q[7:0], hex.value};
          end else begin
            result_o.valid        = 1'b1;
            result_o.decoded_char = {acc_q, hex.value};
          end
        end
        default: begin
          if (c == jsu_pkg::CharBackslash) begin
            mode_d = jsu_pkg::MODE_ESCAPE;
          end else if (c == jsu_pkg::CharQuote) begin
            result_o.valid  = 1'b1;
            result_o.status = jsu_pkg::ST_CLOSED;
          end else begin
            result_o.valid        = 1'b1;
            result_o.decoded_char = c;
          end
        end
      endcase
    end
  end

endmodule

// ----- src/json_string_unescape_top.sv -----
// Top level of the JSON string unescaper: input register, decoder, result register.
// Path: an accepted item waits in the input register, is decoded, and its result is held in the result register.
// Throughput: one code unit per cycle while the result register is empty or out_o.ready is high.
// Items that finish no character (backslash, u, first three hex digits) give no result.
// Reset: rst_ni low clears both registers' valid flags and returns scanning to normal mode.
module json_string_unescape_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  logic              in_valid_q;
  jsu_pkg::in_item_t in_item_q;
  logic              out_valid_q;
  jsu_pkg::status_e  out_status_q;
  logic [15:0]       out_char_q;
  logic              out_free;
  logic              step;
  jsu_pkg::result_t  result;

  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= '{code_unit: in_i.code_unit, text_ended: in_i.text_ended};
    end
  end

  jsu_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && result.valid) begin
      out_status_q <= result.status;
      out_char_q   <= result.decoded_char;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.decoded_char = out_char_q;

endmodule
